FILE: hdl/falu_pkg.sv
package falu_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int NUM_W     = DATA_W + 1 + FRAC_BITS;
   localparam int DEN_W     = DATA_W + 1;
   localparam int FUNC_W    = 4;

   localparam logic [FUNC_W-1:0] OP_ADD   = 4'd0;
   localparam logic [FUNC_W-1:0] OP_SUB   = 4'd1;
   localparam logic [FUNC_W-1:0] OP_MUL   = 4'd2;
   localparam logic [FUNC_W-1:0] OP_DIV   = 4'd3;
   localparam logic [FUNC_W-1:0] OP_EQ    = 4'd4;
   localparam logic [FUNC_W-1:0] OP_NE    = 4'd5;
   localparam logic [FUNC_W-1:0] OP_GT    = 4'd6;
   localparam logic [FUNC_W-1:0] OP_LT    = 4'd7;
   localparam logic [FUNC_W-1:0] OP_GE    = 4'd8;
   localparam logic [FUNC_W-1:0] OP_LE    = 4'd9;
   localparam logic [FUNC_W-1:0] OP_MIN   = 4'd10;
   localparam logic [FUNC_W-1:0] OP_MAX   = 4'd11;
   localparam logic [FUNC_W-1:0] OP_INC   = 4'd12;
   localparam logic [FUNC_W-1:0] OP_DEC   = 4'd13;
   localparam logic [FUNC_W-1:0] OP_FROM  = 4'd14;
   localparam logic [FUNC_W-1:0] OP_TOINT = 4'd15;

   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              neg;
      logic              err;
      logic              flag;
      logic [DATA_W-1:0] value;
      logic [DEN_W-1:0]  rem;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
      logic [DATA_W-1:0] quo;
   } pipe_type;

endpackage

FILE: hdl/falu_req_if.sv
interface falu_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [falu_pkg::FUNC_W-1:0]            func;
   logic signed [falu_pkg::DATA_W-1:0]     opa;
   logic signed [falu_pkg::DATA_W-1:0]     opb;

   modport source (output valid, output func, output opa, output opb, input ready);
   modport sink   (input valid, input func, input opa, input opb, output ready);
endinterface

FILE: hdl/falu_rsp_if.sv
interface falu_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [falu_pkg::DATA_W-1:0]     value;
   logic                                   flag;
   logic                                   error;

   modport source (output valid, output value, output flag, output error, input ready);
   modport sink   (input valid, input value, input flag, input error, output ready);
endinterface

FILE: hdl/falu_front.sv
module falu_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                vld,
   input  logic [falu_pkg::FUNC_W-1:0]         func,
   input  logic signed [falu_pkg::DATA_W-1:0]  opa,
   input  logic signed [falu_pkg::DATA_W-1:0]  opb,
   output falu_pkg::pipe_type                  stage_ff
);

   falu_pkg::pipe_type                       stage_in;
   logic signed [2*falu_pkg::DATA_W-1:0]     product;
   logic signed [2*falu_pkg::DATA_W-1:0]     prod_sh;
   logic [falu_pkg::DEN_W-1:0]               a_ext;
   logic [falu_pkg::DEN_W-1:0]               b_ext;
   logic [falu_pkg::DEN_W-1:0]               a_mag;
   logic [falu_pkg::DEN_W-1:0]               b_mag;
   logic [falu_pkg::NUM_W-1:0]               na;
   logic                                     lt;

   always_comb begin
      product = opa * opb;
      prod_sh = product >>> falu_pkg::FRAC_BITS;
      a_ext   = {opa[falu_pkg::DATA_W-1], opa};
      b_ext   = {opb[falu_pkg::DATA_W-1], opb};
      a_mag   = opa[falu_pkg::DATA_W-1] ? -a_ext : a_ext;
      b_mag   = opb[falu_pkg::DATA_W-1] ? -b_ext : b_ext;
      na      = falu_pkg::NUM_W'(a_mag) << falu_pkg::FRAC_BITS;
      lt      = opa < opb;

      stage_in        = '0;
      stage_in.valid  = vld;
      stage_in.num    = (na << 1) + falu_pkg::NUM_W'(b_mag);
      stage_in.den    = {b_mag[falu_pkg::DATA_W-1:0], 1'b0};
      stage_in.neg    = opa[falu_pkg::DATA_W-1] ^ opb[falu_pkg::DATA_W-1];
      case (func)
         falu_pkg::OP_ADD:   stage_in.value = opa + opb;
         falu_pkg::OP_SUB:   stage_in.value = opa - opb;
         falu_pkg::OP_MUL:   stage_in.value = prod_sh[falu_pkg::DATA_W-1:0];
         falu_pkg::OP_DIV: begin
            stage_in.is_div = (opb != '0);
            stage_in.err    = (opb == '0);
         end
         falu_pkg::OP_EQ:    stage_in.flag  = (opa == opb);
         falu_pkg::OP_NE:    stage_in.flag  = (opa != opb);
         falu_pkg::OP_GT:    stage_in.flag  = (opa > opb);
         falu_pkg::OP_LT:    stage_in.flag  = lt;
         falu_pkg::OP_GE:    stage_in.flag  = (opa >= opb);
         falu_pkg::OP_LE:    stage_in.flag  = (opa <= opb);
         falu_pkg::OP_MIN:   stage_in.value = lt ? opa : opb;
         falu_pkg::OP_MAX:   stage_in.value = lt ? opb : opa;
         falu_pkg::OP_INC:   stage_in.value = opa + 32'sd1;
         falu_pkg::OP_DEC:   stage_in.value = opa - 32'sd1;
         falu_pkg::OP_FROM:  stage_in.value = opa << falu_pkg::FRAC_BITS;
         falu_pkg::OP_TOINT: stage_in.value = opa >>> falu_pkg::FRAC_BITS;
         default:            stage_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

endmodule

FILE: hdl/falu_div_step.sv
module falu_div_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  falu_pkg::pipe_type  stage_in,
   output falu_pkg::pipe_type  stage_ff
);

   falu_pkg::pipe_type            nxt;
   logic [falu_pkg::DEN_W:0]      trial;
   logic                          qbit;

   always_comb begin
      nxt   = stage_in;
      trial = {stage_in.rem, stage_in.num[falu_pkg::NUM_W-1]};
      qbit  = trial >= {1'b0, stage_in.den};
      nxt.rem = qbit ? falu_pkg::DEN_W'(trial - {1'b0, stage_in.den})
                     : trial[falu_pkg::DEN_W-1:0];
      nxt.num = stage_in.num << 1;
      nxt.quo = {stage_in.quo[falu_pkg::DATA_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= nxt;
      end
   end

endmodule

FILE: hdl/fixed_point_alu_core.sv
// fixed-point alu, signed 32-bit raw operands with FRAC_BITS fraction bits
// req channel: func, opa, opb; one transfer per operation
// rsp channel: value, flag, error; exactly one transfer per operation, in order
// every operation travels the same pipeline: an input register, a stage that
// does the multiply and all simple ops, then one restoring divide step per
// numerator bit (FRAC_BITS + 33 steps)
// path: input register, front stage, divide steps; Q24.8 when FRAC_BITS is 8
// throughput: one operation per cycle while the pipeline advances
// the whole pipeline advances when the last stage is empty or rsp.ready is
// high; while the receiver stalls with a result waiting, req.ready is low and
// every stage holds, so nothing is dropped or repeated
// reset (synchronous) clears all valid bits; no results are pending after it
module fixed_point_alu_core (
   input  logic       clock,
   input  logic       reset,
   falu_req_if.sink   req_chan,
   falu_rsp_if.source rsp_chan
);

   logic                                en;
   logic                                a_vld_ff;
   logic [falu_pkg::FUNC_W-1:0]         a_func_ff;
   logic signed [falu_pkg::DATA_W-1:0]  a_opa_ff;
   logic signed [falu_pkg::DATA_W-1:0]  a_opb_ff;
   falu_pkg::pipe_type                  pipe [0:falu_pkg::NUM_W];
   falu_pkg::pipe_type                  last;
   logic [falu_pkg::DATA_W-1:0]         div_val;

   assign last = pipe[falu_pkg::NUM_W];
   assign en   = !last.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_chan.valid;
      end
      if (en) begin
         a_func_ff <= req_chan.func;
         a_opa_ff  <= req_chan.opa;
         a_opb_ff  <= req_chan.opb;
      end
   end

   falu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld      (a_vld_ff),
      .func     (a_func_ff),
      .opa      (a_opa_ff),
      .opb      (a_opb_ff),
      .stage_ff (pipe[0])
   );

   for (genvar i = 0; i < falu_pkg::NUM_W; i++) begin : g_div
      falu_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .stage_in (pipe[i]),
         .stage_ff (pipe[i+1])
      );
   end

   assign div_val        = last.neg ? -last.quo : last.quo;
   assign rsp_chan.valid = last.valid;
   assign rsp_chan.value = last.is_div ? div_val : last.value;
   assign rsp_chan.flag  = last.flag;
   assign rsp_chan.error = last.err;

`ifndef NO_ASSERTIONS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.error |-> rsp_chan.value == '0)
      else $error("divide error with nonzero value");
   a_flag_err: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.flag && rsp_chan.error))
      else $error("flag and error both set");
   a_stall: assert property (@(posedge clock)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input taken while output stalled");
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

   typedef struct packed {
      logic signed [falu_pkg::DATA_W-1:0] value;
      logic                               flag;
      logic                               error;
   } alu_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   fail_count = 0;
   int   sent_count = 0;
   int   checked_count = 0;
   bit   hold_off = 1'b0;
   bit   stim_done = 1'b0;
   alu_result_type expected_results[$];

   localparam int LATENCY     = falu_pkg::FRAC_BITS + 34;
   localparam int CYCLE_LIMIT = 400000;

   falu_req_if req_chan ();
   falu_rsp_if rsp_chan ();

   fixed_point_alu_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   function automatic alu_result_type predict_alu(
         logic [falu_pkg::FUNC_W-1:0] func,
         logic signed [falu_pkg::DATA_W-1:0] a,
         logic signed [falu_pkg::DATA_W-1:0] b);
      alu_result_type r;
      logic signed [63:0] prod;
      logic [63:0] na, nb, q;
      r = '0;
      case (func)
         falu_pkg::OP_ADD: r.value = a + b;
         falu_pkg::OP_SUB: r.value = a - b;
         falu_pkg::OP_MUL: begin
            prod = 64'(a) * 64'(b);
            r.value = 32'(prod >>> falu_pkg::FRAC_BITS);
         end
         falu_pkg::OP_DIV: begin
            if (b == 0) begin
               r.error = 1'b1;
            end else begin
               na = (a < 0 ? -64'(a) : 64'(a)) << falu_pkg::FRAC_BITS;
               nb = b < 0 ? -64'(b) : 64'(b);
               q = (2 * na + nb) / (2 * nb);
               if ((a < 0) != (b < 0)) q = -q;
               r.value = 32'(q);
            end
         end
         falu_pkg::OP_EQ:    r.flag = (a == b);
         falu_pkg::OP_NE:    r.flag = (a != b);
         falu_pkg::OP_GT:    r.flag = (a > b);
         falu_pkg::OP_LT:    r.flag = (a < b);
         falu_pkg::OP_GE:    r.flag = (a >= b);
         falu_pkg::OP_LE:    r.flag = (a <= b);
         falu_pkg::OP_MIN:   r.value = (a < b) ? a : b;
         falu_pkg::OP_MAX:   r.value = (a < b) ? b : a;
         falu_pkg::OP_INC:   r.value = a + 1;
         falu_pkg::OP_DEC:   r.value = a - 1;
         falu_pkg::OP_FROM:  r.value = a <<< falu_pkg::FRAC_BITS;
         default:            r.value = a >>> falu_pkg::FRAC_BITS;
      endcase
      return r;
   endfunction

   // result checker and random receiver stalls
   always @(posedge clock) begin
      alu_result_type exp_r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result value=%0d", rsp_chan.value);
            fail_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_chan.value !== exp_r.value) begin
               $error("value expected %0d actual %0d", exp_r.value, rsp_chan.value);
               fail_count++;
            end
            if (rsp_chan.flag !== exp_r.flag) begin
               $error("flag expected %0b actual %0b", exp_r.flag, rsp_chan.flag);
               fail_count++;
            end
            if (rsp_chan.error !== exp_r.error) begin
               $error("error expected %0b actual %0b", exp_r.error, rsp_chan.error);
               fail_count++;
            end
            checked_count++;
         end
      end
   end

   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            @(posedge clock);
         end else if (stim_done || $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else begin
            gap = $urandom_range(0, 16);
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_chan.ready <= 1'b1;
            do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         end
      end
   end

   task automatic send_op(logic [falu_pkg::FUNC_W-1:0] func,
                          logic signed [falu_pkg::DATA_W-1:0] a,
                          logic signed [falu_pkg::DATA_W-1:0] b, bit idle);
      int gap;
      gap = idle ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func  <= func;
      req_chan.opa   <= a;
      req_chan.opb   <= b;
      do @(posedge clock); while (!req_chan.ready);
      expected_results.push_back(predict_alu(func, a, b));
      sent_count++;
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7fff_ffff - $urandom_range(0, 3);
         2: return 32'($urandom_range(0, 8)) - 32'd4;
         3: return 32'(signed'($urandom_range(0, 4096)) - 2048) <<< falu_pkg::FRAC_BITS;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic signed [falu_pkg::DATA_W-1:0] corners[6];
      corners = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1, 32'sh100};
      for (int f = 0; f < 16; f++)
         send_op(falu_pkg::FUNC_W'(f), corners[f % 6], corners[(f + 3) % 6], 1'b0);
      send_op(falu_pkg::OP_DIV, 32'sh100, 0, 1'b0);
      send_op(falu_pkg::OP_DIV, 32'sh8000_0000, -1, 1'b0);
      send_op(falu_pkg::OP_DIV, 1, 2, 1'b0);
      send_op(falu_pkg::OP_DIV, -1, 2, 1'b0);
      send_op(falu_pkg::OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
      send_op(falu_pkg::OP_INC, 32'sh7fff_ffff, 5, 1'b0);
      send_op(falu_pkg::OP_DEC, 32'sh8000_0000, 5, 1'b0);
      send_op(falu_pkg::OP_TOINT, -1, 0, 1'b0);
      send_op(falu_pkg::OP_MIN, 7, 7, 1'b0);
   endtask

   task automatic test_random(int count, bit allow_idle);
      logic signed [falu_pkg::DATA_W-1:0] a, b;
      bit idle_phase;
      idle_phase = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) idle_phase = allow_idle && ($urandom_range(0, 2) != 0);
         a = rand_operand();
         b = $urandom_range(0, 9) == 0 ? a : rand_operand();
         send_op(falu_pkg::FUNC_W'($urandom_range(0, 15)), a, b, idle_phase);
      end
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random(100, 1'b0);
      join
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.func  <= falu_pkg::OP_ADD;
      req_chan.opa   <= '0;
      req_chan.opb   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(1000, 1'b1);
      req_chan.valid <= 1'b0;
      stim_done = 1'b1;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d operations covering all 16 opcodes and operand corners,", sent_count);
      $display("checked %0d results under random stalls and one long receiver hold-off",
               checked_count);
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
